>>> design/lcns_pkg.sv
// Package for the loop candidate nearest-pair selector.
// Holds request, result and id structs, request and config codes, and shared constants.
package lcns_pkg;

	localparam int MaxQueryDef = 64;
	localparam int MaxKeepDef  = 16;
	localparam int OutLimit    = 16;

	localparam logic [31:0] NodeThrReset   = 32'd65536;
	localparam logic [31:0] TravelThrReset = 32'd655360;
	localparam logic [4:0]  NumCandReset   = 5'd8;

	localparam logic [1:0] CfgNodeThr   = 2'd0;
	localparam logic [1:0] CfgTravelThr = 2'd1;
	localparam logic [1:0] CfgNumCand   = 2'd2;

	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_REF    = 2'd2,
		REQ_FINISH = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [23:0]        node_id;
		logic [15:0]        map_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [47:0]        accum_dist;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [23:0] query_node;
		logic [23:0] ref_node;
		logic [15:0] ref_map;
		logic [63:0] dist_sq;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [23:0] qid;
		logic [23:0] rid;
		logic [15:0] map;
	} pair_ids_t;

	// Squared distance of two positions, saturating at 64 bits.
	function automatic logic [63:0] dist_sq_f(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] bx, input logic [31:0] by);
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic [32:0] adx;
		logic [32:0] ady;
		logic [63:0] sx;
		logic [63:0] sy;
		logic [64:0] s;
		dx = {ax[31], ax} - {bx[31], bx};
		dy = {ay[31], ay} - {by[31], by};
		adx = dx[32] ? 33'(-dx) : 33'(dx);
		ady = dy[32] ? 33'(-dy) : 33'(dy);
		sx = adx[32] ? '1 : adx[31:0] * adx[31:0];
		sy = ady[32] ? '1 : ady[31:0] * ady[31:0];
		s = {1'b0, sx} + {1'b0, sy};
		dist_sq_f = s[64] ? '1 : s[63:0];
	endfunction

endpackage

>>> design/lcns_ctrl.sv
// Controller state machine of the loop candidate selector.
// Depends on lcns_pkg; drives the datapath through command signals.
module lcns_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] req_type,
	input  logic stopped,
	input  logic root_done,
	input  logic scan_done,
	input  logic emit_done,
	output logic busy,
	output logic cmd_accept,
	output logic cmd_root,
	output logic cmd_check,
	output logic cmd_scan,
	output logic cmd_emit
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ROOT  = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_WAIT  = 6'b100000
	} state_t;

	state_t state_q;

	assign busy       = (state_q != ST_IDLE);
	assign cmd_accept = start && !busy;
	assign cmd_root   = (state_q == ST_ROOT);
	assign cmd_check  = (state_q == ST_CHECK);
	assign cmd_scan   = (state_q == ST_SCAN);
	assign cmd_emit   = (state_q == ST_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_accept) begin
						if (req_type == lcns_pkg::REQ_REF && !stopped)
							state_q <= ST_ROOT;
						else if (req_type == lcns_pkg::REQ_FINISH)
							state_q <= ST_EMIT;
					end
				end
				ST_ROOT:  if (root_done) state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_WAIT;
				ST_WAIT:  state_q <= stopped ? ST_IDLE : ST_SCAN;
				ST_SCAN:  if (scan_done) state_q <= ST_IDLE;
				ST_EMIT:  if (emit_done) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/lcns_dpath.sv
// Datapath of the loop candidate selector: query memory, travel root,
// pair distance scan, sorted kept list and result output. Depends on lcns_pkg.
module lcns_dpath #(
	parameter int MAX_QUERY = lcns_pkg::MaxQueryDef,
	parameter int MAX_KEEP  = lcns_pkg::MaxKeepDef
) (
	input  logic clk,
	input  logic arst_n,
	input  lcns_pkg::req_t req,
	input  logic [31:0] node_thr,
	input  logic [31:0] travel_thr,
	input  logic [4:0]  num_cand,
	input  logic cmd_accept,
	input  logic cmd_root,
	input  logic cmd_check,
	input  logic cmd_scan,
	input  logic cmd_emit,
	output logic stopped,
	output logic root_done,
	output logic scan_done,
	output logic emit_done,
	output lcns_pkg::res_t result,
	output logic result_valid
);

	localparam int QW = $clog2(MAX_QUERY + 1);
	localparam int QA = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
	localparam int KW = $clog2(MAX_KEEP + 1);

	logic [63:0] qpos_mem [MAX_QUERY];
	logic [23:0] qid_mem  [MAX_QUERY];
	logic [QW-1:0] qcount_q;

	logic [63:0] best_d_q [MAX_KEEP];
	lcns_pkg::pair_ids_t best_i_q [MAX_KEEP];
	logic [KW-1:0] best_cnt_q;

	logic [63:0] prev_q;
	logic [47:0] travel_q;
	logic [47:0] total_q;
	logic first_q;
	logic stopped_q;

	lcns_pkg::req_t cur_q;
	logic [63:0] rad_q;
	logic [63:0] rem_q;
	logic [63:0] root_q;
	logic [5:0]  rcnt_q;
	logic        rstart_q;

	logic [QW-1:0] rd_idx_q;
	logic          rd_vld_s1;
	logic [63:0]   rd_pos_s1;
	logic [23:0]   rd_id_s1;
	logic [63:0]   d_s2;
	logic [23:0]   id_s2;
	logic          vld_s2;
	logic [63:0]   thr_sq_q;

	logic [KW-1:0] emit_k_q;
	logic [KW-1:0] emit_n;
	logic [KW:0]   nc_ext;

	assign stopped = stopped_q;

	// Restoring square root, two bits per cycle.
	logic [63:0] trial;
	logic [65:0] rem_sh;
	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {root_q[61:0], 2'b01};
	assign root_done = cmd_root && !rstart_q && (rcnt_q == 6'd32);

	logic [47:0] step;
	logic [48:0] tsum;
	logic [47:0] tnew;
	assign step = root_q[47:0];
	assign tsum = {1'b0, travel_q} + {1'b0, (root_q[63:48] != 0) ? 48'hFFFF_FFFF_FFFF : step};
	assign tnew = first_q ? travel_q : (tsum[48] ? '1 : tsum[47:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rstart_q <= 1'b0;
			rcnt_q   <= '0;
		end else if (cmd_accept) begin
			rstart_q <= 1'b1;
		end else if (cmd_root && rstart_q) begin
			rstart_q <= 1'b0;
			rcnt_q   <= '0;
		end else if (cmd_root && rcnt_q != 6'd32) begin
			rcnt_q <= rcnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept)
			cur_q <= req;
		if (cmd_root && rstart_q) begin
			rad_q  <= lcns_pkg::dist_sq_f(prev_q[63:32], prev_q[31:0],
				cur_q.pos_x, cur_q.pos_y);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd_root && rcnt_q != 6'd32) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_sh >= {2'b00, trial}) begin
				rem_q  <= 64'(rem_sh - {2'b00, trial});
				root_q <= {root_q[62:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[63:0];
				root_q <= {root_q[62:0], 1'b0};
			end
		end
		if (cmd_check)
			thr_sq_q <= node_thr * node_thr;
	end

	// Search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q  <= '0;
			prev_q    <= '0;
			travel_q  <= '0;
			total_q   <= '0;
			first_q   <= 1'b1;
			stopped_q <= 1'b0;
		end else if (cmd_accept && req.req_type == lcns_pkg::REQ_START) begin
			qcount_q  <= '0;
			prev_q    <= '0;
			travel_q  <= '0;
			total_q   <= req.accum_dist;
			first_q   <= 1'b1;
			stopped_q <= 1'b0;
		end else if (cmd_accept && req.req_type == lcns_pkg::REQ_QUERY) begin
			if (qcount_q < QW'(MAX_QUERY))
				qcount_q <= qcount_q + QW'(1);
		end else if (cmd_check) begin
			travel_q <= tnew;
			prev_q   <= {cur_q.pos_x, cur_q.pos_y};
			first_q  <= 1'b0;
			if (tnew > total_q || (total_q - tnew) < {16'd0, travel_thr})
				stopped_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept && req.req_type == lcns_pkg::REQ_QUERY && qcount_q < QW'(MAX_QUERY)) begin
			qpos_mem[qcount_q[QA-1:0]] <= {req.pos_x, req.pos_y};
			qid_mem[qcount_q[QA-1:0]]  <= req.node_id;
		end
	end

	// Scan: read one query a cycle, distance stage, then insertion.
	logic rd_go;
	assign rd_go = cmd_scan && rd_idx_q < qcount_q;
	assign scan_done = cmd_scan && !rd_go && !rd_vld_s1 && !vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_go;
			vld_s2    <= rd_vld_s1;
			if (cmd_check)
				rd_idx_q <= '0;
			else if (rd_go)
				rd_idx_q <= rd_idx_q + QW'(1);
		end
	end

	always_ff @(posedge clk) begin
		rd_pos_s1 <= qpos_mem[rd_idx_q[QA-1:0]];
		rd_id_s1  <= qid_mem[rd_idx_q[QA-1:0]];
		d_s2  <= lcns_pkg::dist_sq_f(cur_q.pos_x, cur_q.pos_y, rd_pos_s1[63:32], rd_pos_s1[31:0]);
		id_s2 <= rd_id_s1;
	end

	// Sorted insertion: each slot compares in parallel against the new pair.
	logic [MAX_KEEP-1:0] gt;
	lcns_pkg::pair_ids_t new_ids;
	assign new_ids = '{qid: id_s2, rid: cur_q.node_id, map: cur_q.map_id};

	always_comb begin
		for (int i = 0; i < MAX_KEEP; i++)
			gt[i] = (KW'(i) < best_cnt_q) && (best_d_q[i] > d_s2);
	end

	logic keep;
	assign keep = vld_s2 && (d_s2 < thr_sq_q) &&
		((best_cnt_q < KW'(MAX_KEEP)) || gt[MAX_KEEP-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_cnt_q <= '0;
		end else if (cmd_accept && req.req_type == lcns_pkg::REQ_START) begin
			best_cnt_q <= '0;
		end else if (keep && best_cnt_q < KW'(MAX_KEEP)) begin
			best_cnt_q <= best_cnt_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			for (int i = MAX_KEEP - 1; i >= 0; i--) begin
				if (gt[i]) begin
					if (i == 0 || !gt[i-1]) begin
						best_d_q[i] <= d_s2;
						best_i_q[i] <= new_ids;
					end else begin
						best_d_q[i] <= best_d_q[i-1];
						best_i_q[i] <= best_i_q[i-1];
					end
				end else if (KW'(i) == best_cnt_q) begin
					if (i == 0 || !gt[i-1]) begin
						best_d_q[i] <= d_s2;
						best_i_q[i] <= new_ids;
					end else begin
						best_d_q[i] <= best_d_q[i-1];
						best_i_q[i] <= best_i_q[i-1];
					end
				end
			end
		end
	end

	// Emit.
	always_comb begin
		nc_ext = {1'b0, KW'(0)};
		if ({27'd0, num_cand} < 32'(best_cnt_q))
			nc_ext = (KW+1)'(num_cand);
		else
			nc_ext = {1'b0, best_cnt_q};
		if (nc_ext > (KW+1)'(lcns_pkg::OutLimit))
			nc_ext = (KW+1)'(lcns_pkg::OutLimit);
		emit_n = nc_ext[KW-1:0];
	end

	logic [KW-1:0] ksel;
	assign ksel = (emit_k_q < KW'(MAX_KEEP)) ? emit_k_q : '0;
	assign emit_done = cmd_emit && ((emit_n == '0) || (emit_k_q + KW'(1) >= emit_n));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_k_q     <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd_emit;
			if (cmd_emit && !emit_done)
				emit_k_q <= emit_k_q + KW'(1);
			else
				emit_k_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_n == '0) begin
			result <= '{found: 1'b0, query_node: '0, ref_node: '0, ref_map: '0,
				dist_sq: '0, last: 1'b1};
		end else begin
			result <= '{found: 1'b1, query_node: best_i_q[ksel[$clog2(MAX_KEEP > 1 ? MAX_KEEP : 2)-1:0]].qid,
				ref_node: best_i_q[ksel[$clog2(MAX_KEEP > 1 ? MAX_KEEP : 2)-1:0]].rid,
				ref_map: best_i_q[ksel[$clog2(MAX_KEEP > 1 ? MAX_KEEP : 2)-1:0]].map,
				dist_sq: best_d_q[ksel[$clog2(MAX_KEEP > 1 ? MAX_KEEP : 2)-1:0]],
				last: emit_done};
		end
	end

endmodule

>>> design/loop_candidate_nearest_select.sv
// Top level of the loop candidate nearest-pair selector.
// Instantiates lcns_ctrl and lcns_dpath; depends on lcns_pkg.
//
// Channel   Handshake            Payload
// request   start / busy         req (lcns_pkg::req_t)
// result    result_valid strobe  result (lcns_pkg::res_t)
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Start, query and stopped reference requests are taken in idle without raising busy.
// A live reference holds busy through the root, travel check and wait states; if the
// travel gap is too small it ends there, else the scan reads every stored query and
// then drains its pipeline.
// A finish holds busy while it emits one result per cycle. Reset clears all control state.
// The receiver cannot stall; each result is shown for one cycle.
module loop_candidate_nearest_select #(
	parameter int MAX_QUERY = lcns_pkg::MaxQueryDef,
	parameter int MAX_KEEP  = lcns_pkg::MaxKeepDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  lcns_pkg::req_t req,
	output logic result_valid,
	output lcns_pkg::res_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] node_thr_q;
	logic [31:0] travel_thr_q;
	logic [4:0]  num_cand_q;
	logic stopped, root_done, scan_done, emit_done;
	logic cmd_accept, cmd_root, cmd_check, cmd_scan, cmd_emit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_thr_q   <= lcns_pkg::NodeThrReset;
			travel_thr_q <= lcns_pkg::TravelThrReset;
			num_cand_q   <= lcns_pkg::NumCandReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				lcns_pkg::CfgNodeThr:   node_thr_q   <= cfg_data;
				lcns_pkg::CfgTravelThr: travel_thr_q <= cfg_data;
				lcns_pkg::CfgNumCand:   num_cand_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	lcns_ctrl u_ctrl (
		.clk, .arst_n, .start, .req_type(req.req_type), .stopped, .root_done,
		.scan_done, .emit_done, .busy, .cmd_accept, .cmd_root, .cmd_check,
		.cmd_scan, .cmd_emit
	);

	lcns_dpath #(.MAX_QUERY(MAX_QUERY), .MAX_KEEP(MAX_KEEP)) u_dpath (
		.clk, .arst_n, .req, .node_thr(node_thr_q), .travel_thr(travel_thr_q),
		.num_cand(num_cand_q), .cmd_accept, .cmd_root, .cmd_check, .cmd_scan,
		.cmd_emit, .stopped, .root_done, .scan_done, .emit_done, .result,
		.result_valid
	);

endmodule
